>>> rtl/core/ffrf_pkg.sv
// Shared types and constants for the follow-filtered recent feed.
// No dependencies; ffrf_cell and follow_filtered_recent_feed refer to this package.
package ffrf_pkg;

    localparam int ID_W          = 6;
    localparam int POST_W        = 31;
    localparam int USERS_DEF     = 64;
    localparam int LOG_DEPTH_DEF = 256;
    localparam int FEED_MAX_DEF  = 10;

    typedef enum logic [1:0] {
        REQ_POST     = 2'd0,
        REQ_FEED     = 2'd1,
        REQ_FOLLOW   = 2'd2,
        REQ_UNFOLLOW = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_ROTATE
    } cell_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLLOW_WR,
        ST_SCAN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [POST_W-1:0] post;
        logic [ID_W-1:0]   author;
    } entry_t;

endpackage

>>> rtl/core/ffrf_cell.sv
// One slot of the post log chain: push takes the left neighbor, rotate the right.
// Depends on ffrf_pkg.
module ffrf_cell (
    input  logic                clk,
    input  ffrf_pkg::cell_mode_t mode,
    input  ffrf_pkg::entry_t    left_in,
    input  ffrf_pkg::entry_t    right_in,
    output ffrf_pkg::entry_t    q
);

    ffrf_pkg::entry_t q_reg;
    ffrf_pkg::entry_t q_next;

    always_comb
    begin
        unique case (mode)
            ffrf_pkg::CELL_PUSH:   q_next = left_in;
            ffrf_pkg::CELL_ROTATE: q_next = right_in;
            default:               q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

>>> rtl/core/ffrf_follow_mem.sv
// Follow matrix: one row per user, registered read, row valid bits read as zero.
// Depends on ffrf_pkg only by convention; widths come from parameters.
module ffrf_follow_mem #(
    parameter int USERS = 64,
    parameter int RW    = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [RW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic [RW-1:0]    wr_addr,
    input  logic [USERS-1:0] wr_data,
    output logic [USERS-1:0] rd_data
);

    logic [USERS-1:0] mem [USERS];
    logic [USERS-1:0] row_valid_reg;
    logic [USERS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= row_valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/follow_filtered_recent_feed.sv
// Top level of the follow-filtered recent feed: log chain, follow matrix, scan control.
// Depends on ffrf_pkg, ffrf_cell and ffrf_follow_mem.
//
//  channel | direction | handshake              | fields
//  in      | in        | in_valid / in_stall    | req_type, user_id, other_id, post_id
//  out     | out       | out_valid / out_stall  | feed_post_id, found, last
//
// Post: pushed into the head cell on acceptance. Follow/unfollow: row read, then row write.
// Feed query: the log chain rotates once fully past the head cell, one entry per cycle,
// pausing while a match waits on a stalled output register.
// Reset clears the follow matrix row valid bits, entry count and control at once.
// The output register lets a new request enter while the last result waits.
module follow_filtered_recent_feed #(
    parameter int USERS     = ffrf_pkg::USERS_DEF,
    parameter int LOG_DEPTH = ffrf_pkg::LOG_DEPTH_DEF,
    parameter int FEED_MAX  = ffrf_pkg::FEED_MAX_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  req_type,
    input  logic [ffrf_pkg::ID_W-1:0]   user_id,
    input  logic [ffrf_pkg::ID_W-1:0]   other_id,
    input  logic [ffrf_pkg::POST_W-1:0] post_id,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ffrf_pkg::POST_W-1:0] feed_post_id,
    output logic                        found,
    output logic                        last
);

    localparam int RW   = ($clog2(USERS) > 0) ? $clog2(USERS) : 1;
    localparam int CNTW = $clog2(LOG_DEPTH + 1);
    localparam int NW   = $clog2(FEED_MAX + 1);

    function automatic logic [RW-1:0] id_mod(input logic [ffrf_pkg::ID_W-1:0] v);
        logic [RW-1:0] r;
        r = '0;
        for (int i = 0; i < (1 << ffrf_pkg::ID_W); i++)
        begin
            if (v == ffrf_pkg::ID_W'(i))
            begin
                r = RW'(i % USERS);
            end
        end
        return r;
    endfunction

    ffrf_pkg::state_t     state_reg, state_next;
    ffrf_pkg::cell_mode_t mode;
    ffrf_pkg::entry_t     chain [LOG_DEPTH];
    ffrf_pkg::entry_t     new_entry;

    logic [ffrf_pkg::ID_W-1:0]   user_reg;
    logic [ffrf_pkg::ID_W-1:0]   other_reg;
    logic                        set_reg;
    logic [CNTW-1:0]             count_reg;
    logic [CNTW-1:0]             scan_cnt_reg;
    logic [NW-1:0]               n_reg;
    logic                        pend_valid_reg;
    logic [ffrf_pkg::POST_W-1:0] pend_post_reg;
    logic                        out_valid_reg;
    logic [ffrf_pkg::POST_W-1:0] out_post_reg;
    logic                        out_found_reg;
    logic                        out_last_reg;

    logic             in_accept;
    logic             out_free;
    logic             match;
    logic             eligible;
    logic             scan_adv;
    logic             push_pend;
    logic             emit_pend;
    logic             emit_last;
    logic             emit_empty;
    logic             mem_wr;
    logic [USERS-1:0] row_q;
    logic [USERS-1:0] wr_row;

    assign in_stall  = (state_reg != ffrf_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign new_entry.post   = post_id;
    assign new_entry.author = user_id;

    genvar g;
    generate
        for (g = 0; g < LOG_DEPTH; g++)
        begin : g_cell
            ffrf_cell u_cell (
                .clk      (clk),
                .mode     (mode),
                .left_in  ((g == 0) ? new_entry : chain[(g == 0) ? 0 : g - 1]),
                .right_in ((g == LOG_DEPTH - 1) ? chain[0]
                                                : chain[(g == LOG_DEPTH - 1) ? 0 : g + 1]),
                .q        (chain[g])
            );
        end
    endgenerate

    ffrf_follow_mem #(
        .USERS (USERS),
        .RW    (RW)
    ) u_follow (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (id_mod(user_id)),
        .wr_en   (mem_wr),
        .wr_addr (id_mod(user_reg)),
        .wr_data (wr_row),
        .rd_data (row_q)
    );

    always_comb
    begin
        wr_row = row_q;
        wr_row[id_mod(other_reg)] = set_reg;
    end

    assign match    = (chain[0].author == user_reg) || row_q[id_mod(chain[0].author)];
    assign eligible = (scan_cnt_reg < count_reg) && (n_reg < NW'(FEED_MAX));

    always_comb
    begin
        state_next = state_reg;
        mode       = ffrf_pkg::CELL_HOLD;
        scan_adv   = 1'b0;
        push_pend  = 1'b0;
        emit_pend  = 1'b0;
        emit_last  = 1'b0;
        emit_empty = 1'b0;
        mem_wr     = 1'b0;
        unique case (state_reg)
            ffrf_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (ffrf_pkg::req_t'(req_type))
                        ffrf_pkg::REQ_POST: mode = ffrf_pkg::CELL_PUSH;
                        ffrf_pkg::REQ_FEED: state_next = ffrf_pkg::ST_SCAN;
                        default:            state_next = ffrf_pkg::ST_FOLLOW_WR;
                    endcase
                end
            end
            ffrf_pkg::ST_FOLLOW_WR:
            begin
                mem_wr     = 1'b1;
                state_next = ffrf_pkg::ST_IDLE;
            end
            ffrf_pkg::ST_SCAN:
            begin
                if (eligible && match)
                begin
                    // hold the chain while an older match cannot leave pending
                    if (!pend_valid_reg || out_free)
                    begin
                        scan_adv  = 1'b1;
                        push_pend = 1'b1;
                        emit_pend = pend_valid_reg;
                    end
                end
                else
                begin
                    scan_adv = 1'b1;
                end
                if (scan_adv)
                begin
                    mode = ffrf_pkg::CELL_ROTATE;
                    if (scan_cnt_reg == CNTW'(LOG_DEPTH - 1))
                    begin
                        state_next = ffrf_pkg::ST_FIN;
                    end
                end
            end
            ffrf_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    emit_pend  = pend_valid_reg;
                    emit_last  = 1'b1;
                    emit_empty = !pend_valid_reg;
                    state_next = ffrf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffrf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffrf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            scan_cnt_reg   <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (mode == ffrf_pkg::CELL_PUSH && count_reg < CNTW'(LOG_DEPTH))
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (in_accept)
            begin
                scan_cnt_reg   <= '0;
                n_reg          <= '0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (scan_adv)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (push_pend)
                begin
                    n_reg          <= n_reg + 1'b1;
                    pend_valid_reg <= 1'b1;
                end
                else if (emit_last)
                begin
                    pend_valid_reg <= 1'b0;
                end
            end
            if (emit_pend || emit_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            user_reg  <= user_id;
            other_reg <= other_id;
            set_reg   <= (ffrf_pkg::req_t'(req_type) == ffrf_pkg::REQ_FOLLOW);
        end
        if (push_pend)
        begin
            pend_post_reg <= chain[0].post;
        end
        if (emit_pend)
        begin
            out_post_reg  <= pend_post_reg;
            out_found_reg <= 1'b1;
            out_last_reg  <= emit_last;
        end
        else if (emit_empty)
        begin
            out_post_reg  <= '0;
            out_found_reg <= 1'b0;
            out_last_reg  <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign feed_post_id = out_post_reg;
    assign found        = out_found_reg;
    assign last         = out_last_reg;

endmodule

>>> tb/sv/ffrf_checker.sv
// Checker for follow_filtered_recent_feed: watches both channels and predicts feed results.
// Depends on ffrf_pkg; instantiated beside the block by tb_top.
`timescale 1ns / 1ps
module ffrf_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [1:0]                  req_type,
    input  logic [ffrf_pkg::ID_W-1:0]   user_id,
    input  logic [ffrf_pkg::ID_W-1:0]   other_id,
    input  logic [ffrf_pkg::POST_W-1:0] post_id,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [ffrf_pkg::POST_W-1:0] feed_post_id,
    input  logic                        found,
    input  logic                        last,
    output int                          fail_count,
    output int                          pending,
    output int                          results_seen
);

    localparam int USERS = ffrf_pkg::USERS_DEF;
    localparam int DEPTH = ffrf_pkg::LOG_DEPTH_DEF;
    localparam int FMAX  = ffrf_pkg::FEED_MAX_DEF;

    typedef struct packed {
        logic [ffrf_pkg::POST_W-1:0] pid;
        logic                        fnd;
        logic                        lst;
    } feed_res_t;

    logic [USERS-1:0]            follows [USERS];
    logic [ffrf_pkg::POST_W-1:0] log_pid [DEPTH];
    logic [ffrf_pkg::ID_W-1:0]   log_auth [DEPTH];
    int                          wr_ptr;
    int                          n_entries;
    feed_res_t                   feed_q [$];

    assign pending = feed_q.size();

    task automatic model_request(input logic [1:0] kind,
                                 input logic [ffrf_pkg::ID_W-1:0] uid,
                                 input logic [ffrf_pkg::ID_W-1:0] oid,
                                 input logic [ffrf_pkg::POST_W-1:0] pid);
        int n;
        int pos;
        int s;
        feed_res_t r;
        case (ffrf_pkg::req_t'(kind))
            ffrf_pkg::REQ_POST:
            begin
                log_pid[wr_ptr] = pid;
                log_auth[wr_ptr] = uid;
                wr_ptr = (wr_ptr + 1) % DEPTH;
                if (n_entries < DEPTH)
                    n_entries++;
            end
            ffrf_pkg::REQ_FOLLOW:   follows[uid % USERS][oid % USERS] = 1'b1;
            ffrf_pkg::REQ_UNFOLLOW: follows[uid % USERS][oid % USERS] = 1'b0;
            default:
            begin
                n = 0;
                pos = wr_ptr;
                for (s = 0; s < n_entries && n < FMAX; s++)
                begin
                    pos = (pos + DEPTH - 1) % DEPTH;
                    if (log_auth[pos] == uid || follows[uid % USERS][log_auth[pos] % USERS])
                    begin
                        r.pid = log_pid[pos];
                        r.fnd = 1'b1;
                        r.lst = 1'b0;
                        feed_q = {feed_q, r};
                        n++;
                    end
                end
                if (n == 0)
                begin
                    r = '0;
                    r.lst = 1'b1;
                    feed_q = {feed_q, r};
                end
                else
                    feed_q[feed_q.size() - 1].lst = 1'b1;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        feed_res_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < USERS; i++)
                follows[i] = '0;
            wr_ptr = 0;
            n_entries = 0;
            feed_q.delete();
            fail_count <= 0;
            results_seen <= 0;
        end
        else
        begin
            // compare before predicting so a same-edge request cannot queue ahead
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (feed_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: id=%0d found=%0b last=%0b",
                                 feed_post_id, found, last);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = feed_q.pop_front();
                    if (e.pid !== feed_post_id || e.fnd !== found || e.lst !== last)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                     e.pid, e.fnd, e.lst, feed_post_id, found, last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                model_request(req_type, user_id, other_id, post_id);
        end
    end
endmodule

>>> tb/sv/tb_top.sv
// Top of the follow_filtered_recent_feed testbench: clock, reset, stimulus and verdict.
// Depends on ffrf_pkg, the block and ffrf_checker.
`timescale 1ns / 1ps
module tb_top;

    localparam int WATCHDOG = 20000;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [1:0]                  req_type;
    logic [ffrf_pkg::ID_W-1:0]   user_id;
    logic [ffrf_pkg::ID_W-1:0]   other_id;
    logic [ffrf_pkg::POST_W-1:0] post_id;
    logic                        out_valid;
    logic                        out_stall;
    logic [ffrf_pkg::POST_W-1:0] feed_post_id;
    logic                        found;
    logic                        last;
    int                          fail_count;
    int                          pending;
    int                          results_seen;
    int                          idle_cycles;
    int                          feeds_sent;
    int                          posts_sent;
    int                          cyc;
    bit                          no_idle;

    follow_filtered_recent_feed u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .user_id(user_id), .other_id(other_id), .post_id(post_id),
        .out_valid(out_valid), .out_stall(out_stall), .feed_post_id(feed_post_id),
        .found(found), .last(last)
    );

    ffrf_checker u_chk (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .user_id(user_id), .other_id(other_id), .post_id(post_id),
        .out_valid(out_valid), .out_stall(out_stall), .feed_post_id(feed_post_id),
        .found(found), .last(last), .fail_count(fail_count), .pending(pending),
        .results_seen(results_seen)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // receiver back-pressure, with a quiet window in the middle of the run
    always @(negedge clk)
    begin
        cyc <= cyc + 1;
        if (no_idle)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 16);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog expired");
            $display("follow_filtered_recent_feed verification failed");
            $finish;
        end
    end

    // hold the transfer until accepted, then maybe idle; valid stays up for the next send
    task automatic send(input ffrf_pkg::req_t kind, input logic [ffrf_pkg::ID_W-1:0] uid,
                        input logic [ffrf_pkg::ID_W-1:0] oid,
                        input logic [ffrf_pkg::POST_W-1:0] pid);
        in_valid <= 1'b1;
        req_type <= kind;
        user_id <= uid;
        other_id <= oid;
        post_id <= pid;
        if (kind == ffrf_pkg::REQ_FEED)
            feeds_sent++;
        if (kind == ffrf_pkg::REQ_POST)
            posts_sent++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        if (!no_idle)
        begin
            while ($urandom_range(99) < 16)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (ffrf_pkg::LOG_DEPTH_DEF + 20) @(negedge clk);
    endtask

    initial
    begin
        logic [ffrf_pkg::ID_W-1:0] u;
        int r;
        int seq;
        cyc = 0;
        no_idle = 1'b0;
        feeds_sent = 0;
        posts_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        req_type = '0;
        user_id = '0;
        other_id = '0;
        post_id = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty feed, self posts, follow, self follow, unfollow, extremes
        send(ffrf_pkg::REQ_FEED, 6'd0, 6'd0, '0);
        send(ffrf_pkg::REQ_POST, 6'd0, 6'd63, 31'h7FFFFFFF);
        send(ffrf_pkg::REQ_POST, 6'd63, 6'd0, 31'd0);
        send(ffrf_pkg::REQ_FEED, 6'd0, 6'd63, 31'h7FFFFFFF);
        send(ffrf_pkg::REQ_FEED, 6'd63, 6'd0, '0);
        send(ffrf_pkg::REQ_FEED, 6'd5, 6'd0, '0);
        send(ffrf_pkg::REQ_UNFOLLOW, 6'd5, 6'd63, '0);
        send(ffrf_pkg::REQ_FOLLOW, 6'd5, 6'd63, '0);
        send(ffrf_pkg::REQ_FOLLOW, 6'd5, 6'd5, '0);
        send(ffrf_pkg::REQ_FEED, 6'd5, 6'd0, '0);
        send(ffrf_pkg::REQ_FOLLOW, 6'd63, 6'd0, 31'h2AAAAAAA);
        send(ffrf_pkg::REQ_FEED, 6'd63, 6'd0, 31'h55555555);
        for (int i = 0; i < 12; i++)
            send(ffrf_pkg::REQ_POST, 6'd63, '0, 31'(i * 977 + 1));
        send(ffrf_pkg::REQ_FEED, 6'd5, 6'd0, '0);
        send(ffrf_pkg::REQ_UNFOLLOW, 6'd5, 6'd63, '0);
        send(ffrf_pkg::REQ_FEED, 6'd5, 6'd0, '0);

        // pause the sender until every expected result is out
        drain();

        // random: bursts of posts by a few users, follow churn, queries
        seq = 0;
        while (seq < 240)
        begin
            no_idle = (seq >= 150 && seq < 210);
            r = $urandom_range(99);
            u = (r < 80) ? 6'($urandom_range(7)) : 6'($urandom);
            if (r < 45)
                send(ffrf_pkg::REQ_POST, u, 6'($urandom), 31'($urandom));
            else if (r < 65)
                send(ffrf_pkg::REQ_FOLLOW, u, ($urandom_range(3) == 0) ? 6'($urandom)
                                                              : 6'($urandom_range(7)), '0);
            else if (r < 75)
                send(ffrf_pkg::REQ_UNFOLLOW, u, 6'($urandom_range(7)), 31'($urandom));
            else
                send(ffrf_pkg::REQ_FEED, u, 6'($urandom), 31'($urandom));
            seq++;
        end
        no_idle = 1'b0;

        // wrap the log past its depth, then query
        while (posts_sent < ffrf_pkg::LOG_DEPTH_DEF + 8)
            send(ffrf_pkg::REQ_POST, 6'($urandom_range(15)), '0, 31'($urandom));
        for (int i = 0; i < 6; i++)
            send(ffrf_pkg::REQ_FEED, 6'($urandom_range(15)), '0, '0);

        drain();
        $display("%0d feed queries, %0d results checked, log wrapped, %0d cycles",
                 feeds_sent, results_seen, cyc);
        if (fail_count == 0)
            $display("follow_filtered_recent_feed verification clean");
        else
            $display("follow_filtered_recent_feed verification failed");
        $finish;
    end
endmodule
